>>> hdl/multi_waveform_oscillator_defines.svh
// Assertion macros used by the oscillator's port-level checker.
// No dependencies.
`ifndef MULTI_WAVEFORM_OSCILLATOR_DEFINES_SVH
`define MULTI_WAVEFORM_OSCILLATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MWO_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mwo assertion failed");

// next-cycle implication, disabled in reset
`define MWO_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mwo assertion failed");

`endif

>>> hdl/mwo_pkg.sv
// Package for the multi-waveform oscillator: widths, codes, divider types
// and the quarter-wave sine table builder. No dependencies.
package mwo_pkg;

  localparam int unsigned SR_W   = 18;
  localparam int unsigned HC_W   = 7;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned N_W    = 31;
  localparam int unsigned F_W    = 25;
  localparam int unsigned OUT_W  = 20;
  localparam int unsigned MOD_W  = SR_W + 8;

  localparam int unsigned MAX_HARMONICS = 64;
  localparam int unsigned H_W = $clog2(MAX_HARMONICS + 3);
  localparam int unsigned W_W = 2 * H_W;

  localparam int unsigned SINE_DEPTH = 1024;
  localparam int unsigned SINE_AW    = $clog2(SINE_DEPTH);
  localparam int unsigned IDX_W      = SINE_AW + 2;
  localparam int unsigned SINE_VW    = 17;
  localparam int unsigned TERM_W     = SINE_VW + 16;
  localparam int unsigned ACC_W      = TERM_W + 1 + $clog2(MAX_HARMONICS);

  localparam int unsigned DIV_LO_W  = 50;
  localparam int unsigned DIV_REM_W = 32;
  localparam int unsigned DIV_CNT_W = 6;
  localparam int unsigned SAW_SH    = 17;
  localparam int unsigned TRI_SH    = 18;
  localparam int unsigned RATIO_W   = TRI_SH;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = SR_W;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HARMONIC_COUNT = 2'd1;
  localparam logic [SR_W-1:0] SR_RESET = 18'd20000;
  localparam logic [HC_W-1:0] HC_RESET = 7'd50;

  localparam longint HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [MODE_W-1:0] {
    MODE_SINE       = 3'd0,
    MODE_ADD_SAW    = 3'd1,
    MODE_ADD_SQUARE = 3'd2,
    MODE_ADD_TRI    = 3'd3,
    MODE_PSG_SAW    = 3'd4,
    MODE_PSG_SQUARE = 3'd5,
    MODE_PSG_TRI    = 3'd6,
    MODE_OFF        = 3'd7
  } mode_e;

  typedef struct packed {
    logic                 start;
    logic [DIV_REM_W-1:0] rem0;
    logic [DIV_LO_W-1:0]  lo;
    logic [DIV_CNT_W-1:0] cnt;
    logic [DIV_REM_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic [DIV_LO_W-1:0]  quo;
    logic [DIV_REM_W-1:0] rem;
  } div_rsp_t;

  typedef logic [SINE_VW-1:0] sine_rom_t [SINE_DEPTH+1];

  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] term;
    longint      sum;
    longint      v;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) / SINE_DEPTH;
      term = x;
      sum  = longint'(x);
      for (int j = 1; j < 12; j++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = div_u64(term, 64'(2 * j) * 64'(2 * j + 1));
        if ((j % 2) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (sum + 8192) >>> 14;
      if (v > 65536) v = 65536;
      rom[k] = SINE_VW'(v);
    end
    return rom;
  endfunction

endpackage

>>> hdl/mwo_divider.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on mwo_pkg.
module mwo_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mwo_pkg::div_req_t req_i,
  output mwo_pkg::div_rsp_t rsp_o
);
  import mwo_pkg::*;

  logic [DIV_REM_W-1:0] rem_q, rem_d;
  logic [DIV_LO_W-1:0]  lo_q, lo_d;
  logic [DIV_REM_W-1:0] den_q, den_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_REM_W:0]   trial;
  logic                 fits;

  always_comb begin
    trial = {rem_q, lo_q[DIV_LO_W-1]};
    fits  = trial >= {1'b0, den_q};
    rem_d = rem_q;
    lo_d  = lo_q;
    den_d = den_q;
    cnt_d = cnt_q;
    if (req_i.start) begin
      rem_d = req_i.rem0;
      lo_d  = req_i.lo;
      den_d = req_i.den;
      cnt_d = req_i.cnt;
    end else if (cnt_q != '0) begin
      rem_d = fits ? DIV_REM_W'(trial - {1'b0, den_q}) : DIV_REM_W'(trial);
      lo_d  = {lo_q[DIV_LO_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = cnt_q != '0;
  assign rsp_o.quo  = lo_q;
  assign rsp_o.rem  = rem_q;

endmodule

>>> hdl/multi_waveform_oscillator.sv
// Multi-waveform oscillator top level: sequencer, modular phase unit,
// sine ROM and accumulator. Depends on mwo_pkg and mwo_divider.
//
// One word in gives one Q3.16 sample out; the input stalls while a word is
// worked on. All divisions run through one restoring divider at one quotient
// bit per cycle, which sets the latency. The additive modes sum the harmonics
// in turn, skipping the even ones in the square and triangle sums; the PSG
// modes skip the period division at zero frequency, and the unused mode code
// gives a zero sample directly. The finished sample waits in an output
// register, so the next word can be taken while it is stalled.
module multi_waveform_oscillator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [mwo_pkg::MODE_W-1:0]       in_mode_i,
  input  logic [mwo_pkg::N_W-1:0]          in_sample_index_i,
  input  logic [mwo_pkg::F_W-1:0]          in_frequency_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [mwo_pkg::OUT_W-1:0] out_sample_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mwo_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mwo_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import mwo_pkg::*;

  typedef enum logic [19:0] {
    S_IDLE    = 20'h00001,
    S_FMOD    = 20'h00002,
    S_FMOD_W  = 20'h00004,
    S_BASE    = 20'h00008,
    S_IDX     = 20'h00010,
    S_IDX_W   = 20'h00020,
    S_ROM     = 20'h00040,
    S_TERM    = 20'h00080,
    S_TERM_W  = 20'h00100,
    S_ACC     = 20'h00200,
    S_ADV     = 20'h00400,
    S_ROUND   = 20'h00800,
    S_T0      = 20'h01000,
    S_T0_W    = 20'h02000,
    S_PH      = 20'h04000,
    S_PH_W    = 20'h08000,
    S_RATIO   = 20'h10000,
    S_RATIO_W = 20'h20000,
    S_PSG     = 20'h40000,
    S_DONE    = 20'h80000
  } state_e;

  localparam sine_rom_t SineRom = build_sine_rom();
  localparam logic signed [ACC_W-1:0] ResMax = ACC_W'(524287);
  localparam logic signed [ACC_W-1:0] ResMin = -ACC_W'(524288);
  localparam logic signed [ACC_W-1:0] OneQ16 = ACC_W'(65536);
  localparam logic signed [ACC_W-1:0] ThreeQ16 = ACC_W'(196608);

  state_e state_q, state_d;
  logic [SR_W-1:0] sr_q;
  logic [HC_W-1:0] hc_q;
  mode_e mode_q, mode_d;
  logic [N_W-1:0] n_q, n_d;
  logic [F_W-1:0] freq_q, freq_d;
  logic [MOD_W-1:0] addend_q, addend_d, base_q, base_d, r_q, r_d;
  logic [N_W-1:0] nsh_q, nsh_d;
  logic [4:0] bit_cnt_q, bit_cnt_d;
  logic [H_W-1:0] h_q, h_d, hmax_q, hmax_d, h_next;
  logic [W_W-1:0] w_q, w_d;
  logic [SINE_VW-1:0] rom_q;
  logic neg_q, neg_d;
  logic signed [ACC_W-1:0] acc_q, acc_d, res_q, res_d;
  logic [DIV_REM_W-1:0] t0_q, t0_d, ph_q, ph_d;
  logic [RATIO_W-1:0] ratio_q, ratio_d;
  logic signed [OUT_W-1:0] sample_q, sample_d;
  logic out_valid_q, out_valid_d;
  logic [MOD_W-1:0] modulus;
  logic [SINE_AW:0] rom_addr;
  logic [IDX_W-1:0] idx;
  logic [HC_W+H_W-1:0] hc_ext;
  logic [ACC_W-1:0] acc_mag, rnd_mag;
  logic signed [ACC_W-1:0] term_s, ratio_s;
  logic term_neg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  function automatic logic [MOD_W-1:0] mod_add(logic [MOD_W-1:0] a, logic [MOD_W-1:0] b,
                                               logic [MOD_W-1:0] m);
    logic [MOD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, m}) ? MOD_W'(s - {1'b0, m}) : MOD_W'(s);
  endfunction

  mwo_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign modulus = {((sr_q == '0) ? SR_W'(1) : sr_q), 8'd0};
  assign idx     = div_rsp.quo[IDX_W-1:0];
  assign rom_addr = idx[SINE_AW] ? (SINE_AW+1)'(SINE_DEPTH) - {1'b0, idx[SINE_AW-1:0]}
                                 : {1'b0, idx[SINE_AW-1:0]};
  assign hc_ext  = (HC_W+H_W)'(hc_q);
  assign h_next  = h_q + 1'b1;
  assign acc_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign rnd_mag = (acc_mag + ACC_W'(32768)) >> 16;
  assign term_s  = $signed(ACC_W'(div_rsp.quo[TERM_W-1:0]));
  assign term_neg = neg_q ^ ((mode_q == MODE_ADD_TRI) && h_q[1]);
  assign ratio_s = $signed(ACC_W'(ratio_q));

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    n_d         = n_q;
    freq_d      = freq_q;
    addend_d    = addend_q;
    base_d      = base_q;
    r_d         = r_q;
    nsh_d       = nsh_q;
    bit_cnt_d   = bit_cnt_q;
    h_d         = h_q;
    hmax_d      = hmax_q;
    w_d         = w_q;
    neg_d       = neg_q;
    acc_d       = acc_q;
    res_d       = res_q;
    t0_d        = t0_q;
    ph_d        = ph_q;
    ratio_d     = ratio_q;
    sample_d    = sample_q;
    out_valid_d = out_valid_q;
    div_req     = '0;

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d = mode_e'(in_mode_i);
          n_d    = in_sample_index_i;
          freq_d = in_frequency_i;
          h_d    = H_W'(1);
          acc_d  = '0;
          if (mode_e'(in_mode_i) == MODE_SINE) hmax_d = H_W'(1);
          else if (hc_ext > (HC_W+H_W)'(MAX_HARMONICS)) hmax_d = H_W'(MAX_HARMONICS);
          else hmax_d = H_W'(hc_ext);
          priority if (in_mode_i == MODE_OFF) begin
            res_d   = '0;
            state_d = S_DONE;
          end else if (in_mode_i == MODE_PSG_SAW || in_mode_i == MODE_PSG_SQUARE ||
                       in_mode_i == MODE_PSG_TRI) begin
            state_d = S_T0;
          end else begin
            state_d = S_FMOD;
          end
        end
      end
      S_FMOD: begin
        div_req.start = 1'b1;
        div_req.lo    = DIV_LO_W'(freq_q) << (DIV_LO_W - F_W);
        div_req.cnt   = DIV_CNT_W'(F_W);
        div_req.den   = DIV_REM_W'(modulus);
        state_d = S_FMOD_W;
      end
      S_FMOD_W: begin
        if (!div_rsp.busy) begin
          addend_d  = MOD_W'(div_rsp.rem);
          base_d    = '0;
          nsh_d     = n_q;
          bit_cnt_d = 5'(N_W);
          state_d   = S_BASE;
        end
      end
      S_BASE: begin
        if (bit_cnt_q != '0) begin
          if (nsh_q[0]) base_d = mod_add(base_q, addend_q, modulus);
          addend_d  = mod_add(addend_q, addend_q, modulus);
          nsh_d     = nsh_q >> 1;
          bit_cnt_d = bit_cnt_q - 1'b1;
        end else begin
          r_d     = base_q;
          state_d = (hmax_q == '0) ? S_ROUND : S_IDX;
        end
      end
      S_IDX: begin
        div_req.start = 1'b1;
        div_req.rem0  = DIV_REM_W'(r_q);
        div_req.cnt   = DIV_CNT_W'(IDX_W);
        div_req.den   = DIV_REM_W'(modulus);
        w_d = (mode_q == MODE_ADD_TRI) ? W_W'(h_q * h_q) : W_W'(h_q);
        state_d = S_IDX_W;
      end
      S_IDX_W: begin
        if (!div_rsp.busy) state_d = S_ROM;
      end
      S_ROM: begin
        neg_d   = idx[IDX_W-1];
        state_d = S_TERM;
      end
      S_TERM: begin
        div_req.start = 1'b1;
        div_req.lo    = DIV_LO_W'(rom_q) << (DIV_LO_W - SINE_VW);
        div_req.cnt   = DIV_CNT_W'(TERM_W);
        div_req.den   = DIV_REM_W'(w_q);
        state_d = S_TERM_W;
      end
      S_TERM_W: begin
        if (!div_rsp.busy) state_d = S_ACC;
      end
      S_ACC: begin
        acc_d   = term_neg ? acc_q - term_s : acc_q + term_s;
        state_d = S_ADV;
      end
      S_ADV: begin
        r_d = mod_add(r_q, base_q, modulus);
        h_d = h_next;
        priority if (mode_q != MODE_SINE && mode_q != MODE_ADD_SAW && !h_next[0]) begin
          state_d = S_ADV;
        end else if (h_next > hmax_q) begin
          state_d = S_ROUND;
        end else begin
          state_d = S_IDX;
        end
      end
      S_ROUND: begin
        res_d   = acc_q[ACC_W-1] ? -$signed(rnd_mag) : $signed(rnd_mag);
        state_d = S_DONE;
      end
      S_T0: begin
        if (freq_q == '0) begin
          t0_d    = DIV_REM_W'(64'd2147483648);
          state_d = S_PH;
        end else begin
          div_req.start = 1'b1;
          div_req.lo    = DIV_LO_W'(modulus) << (DIV_LO_W - MOD_W);
          div_req.cnt   = DIV_CNT_W'(MOD_W);
          div_req.den   = DIV_REM_W'(freq_q);
          state_d = S_T0_W;
        end
      end
      S_T0_W: begin
        if (!div_rsp.busy) begin
          t0_d = (div_rsp.quo[MOD_W-1:0] == '0) ? DIV_REM_W'(1)
                                               : DIV_REM_W'(div_rsp.quo[MOD_W-1:0]);
          state_d = S_PH;
        end
      end
      S_PH: begin
        div_req.start = 1'b1;
        div_req.lo    = DIV_LO_W'(n_q) << (DIV_LO_W - N_W);
        div_req.cnt   = DIV_CNT_W'(N_W);
        div_req.den   = t0_q;
        state_d = S_PH_W;
      end
      S_PH_W: begin
        if (!div_rsp.busy) begin
          ph_d    = div_rsp.rem;
          state_d = (mode_q == MODE_PSG_SQUARE) ? S_PSG : S_RATIO;
        end
      end
      S_RATIO: begin
        div_req.start = 1'b1;
        div_req.rem0  = ph_q;
        div_req.cnt   = (mode_q == MODE_PSG_SAW) ? DIV_CNT_W'(SAW_SH) : DIV_CNT_W'(TRI_SH);
        div_req.den   = t0_q;
        state_d = S_RATIO_W;
      end
      S_RATIO_W: begin
        if (!div_rsp.busy) begin
          ratio_d = div_rsp.quo[RATIO_W-1:0];
          state_d = S_PSG;
        end
      end
      S_PSG: begin
        priority if (mode_q == MODE_PSG_SAW) begin
          res_d = OneQ16 - ratio_s;
        end else if (mode_q == MODE_PSG_SQUARE) begin
          res_d = (ph_q < (t0_q >> 1)) ? OneQ16 : -OneQ16;
        end else begin
          res_d = (ph_q < (t0_q >> 1)) ? ratio_s - OneQ16 : ThreeQ16 - ratio_s;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          priority if (res_q > ResMax) sample_d = OUT_W'(ResMax);
          else if (res_q < ResMin) sample_d = OUT_W'(ResMin);
          else sample_d = OUT_W'(res_q);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      sr_q        <= SR_RESET;
      hc_q        <= HC_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_SAMPLE_RATE) sr_q <= cfg_data_i;
        else if (cfg_index_i == CFG_HARMONIC_COUNT) hc_q <= cfg_data_i[HC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    n_q       <= n_d;
    freq_q    <= freq_d;
    addend_q  <= addend_d;
    base_q    <= base_d;
    r_q       <= r_d;
    nsh_q     <= nsh_d;
    bit_cnt_q <= bit_cnt_d;
    h_q       <= h_d;
    hmax_q    <= hmax_d;
    w_q       <= w_d;
    neg_q     <= neg_d;
    acc_q     <= acc_d;
    res_q     <= res_d;
    t0_q      <= t0_d;
    ph_q      <= ph_d;
    ratio_q   <= ratio_d;
    sample_q  <= sample_d;
    rom_q     <= SineRom[rom_addr];
  end

  assign in_stall_o   = state_q != S_IDLE;
  assign out_valid_o  = out_valid_q;
  assign out_sample_o = sample_q;
  assign cfg_ready_o  = 1'b1;

endmodule

>>> hdl/mwo_checker.sv
// Port-level checker for the multi-waveform oscillator, bound to the top.
// Depends on mwo_pkg and multi_waveform_oscillator_defines.svh.
`include "multi_waveform_oscillator_defines.svh"

module mwo_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic signed [mwo_pkg::OUT_W-1:0] out_sample_o
);
  import mwo_pkg::*;

  `MWO_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `MWO_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_sample_o))
  `MWO_ASSERT_IMPL(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind multi_waveform_oscillator mwo_checker u_mwo_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_sample_o (out_sample_o)
);
